@@ src/tccw_pkg.sv @@
// shared types and constants for the text console cell writer
package tccw_pkg;

    // request kinds carried in the input tuser bit
    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // control characters and the blank used by tab
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_SPACE = 8'h20;

    // attribute after reset: light grey
    localparam logic [7:0] ATTR_RESET = 8'h07;

    // field widths of the stream words
    localparam int CHAR_W     = 8;
    localparam int INDEX_W    = 11;
    localparam int CELL_W     = 16;
    localparam int OUT_COL_W  = 7;
    localparam int OUT_ROW_W  = 5;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    // sequencer states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_TAB,
        S_SCROLL,
        S_DONE
    } t_state;

endpackage

@@ src/text_console_cell_writer.sv @@
// text console: screen store, cursor and the request sequencer
//
// Usage
//   Requests enter on the slave stream (i_s_*): tuser is the request kind
//   (put character or read cell), tdata carries the character byte and the
//   cell index. Each accepted request gives exactly one result word on the
//   master stream (o_m_*): cell value, cursor column and row, scroll flag.
//   The attribute byte for written characters is set through the cfg
//   channel, which is always ready.
//   The screen lives in one single-port-write RAM of COLUMNS*ROWS cells used
//   as a ring of rows: a scroll moves the top-row offset by one row and then
//   zeroes the recycled row, one cell per cycle.
//   A read waits for the registered RAM read, a tab writes one space per
//   cycle up to the next tab stop or the row end, and a step that scrolls
//   also waits for the recycled row to be zeroed.
//   One request is in work at a time; a new one is taken once the previous
//   result sits in the output register, so a stalled receiver holds at most
//   one finished word plus the request behind it.
//   After reset the RAM is zeroed one cell per cycle, all ROWS*COLUMNS cells
//   (2000 at the defaults), during which o_s_tready stays low.
module text_console_cell_writer
    import tccw_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // char_code, cell_index
    input  logic                   i_s_tuser,   // req_type
    // result stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // cell_data, cursor_col, cursor_row, scrolled
    // attribute register write
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [7:0]             i_cfg_data
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int SUM_W      = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int PH_W       = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int LAST_POS   = (ROWS - 1) * COLUMNS;

    // screen ring
    logic [CELL_W-1:0] mem [CELL_COUNT];

    t_state r_state, n_state;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [AW-1:0]     r_pos, n_pos;
    logic [PH_W-1:0]   r_ph, n_ph;
    logic [AW-1:0]     r_base, n_base;
    logic [AW-1:0]     r_clr_addr, n_clr_addr;
    logic [COL_W-1:0]  r_clr_cnt, n_clr_cnt;
    logic [7:0]        r_attr;
    logic [CELL_W-1:0] r_res_data, n_res_data;
    logic              r_res_scr, n_res_scr;
    logic              r_oob;
    logic [CELL_W-1:0] r_rd_data;
    logic              r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    logic               w_acc;
    logic               w_req;
    logic [CHAR_W-1:0]  w_char;
    logic [INDEX_W-1:0] w_idx;
    logic [AW-1:0]      w_raddr;
    logic               w_oob;
    logic [AW-1:0]      w_cur_addr;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [CELL_W-1:0]  w_wdata;
    logic               w_adv_wrap;
    logic               w_adv_scroll;
    logic [COL_W-1:0]   w_adv_col;
    logic [ROW_W-1:0]   w_adv_row;
    logic [PH_W-1:0]    w_adv_ph;
    logic [AW:0]        w_base_sum;
    logic [AW-1:0]      w_base_next;
    logic [COL_W+OUT_COL_W-1:0] w_col_ext;
    logic [ROW_W+OUT_ROW_W-1:0] w_row_ext;

    // logical position to ring address
    function automatic logic [AW-1:0] ring_addr(input logic [SUM_W-1:0] v,
                                                input logic [AW-1:0] base);
        logic [SUM_W-1:0] s;
        s = v + SUM_W'(base);
        if (s >= SUM_W'(CELL_COUNT)) begin
            s = s - SUM_W'(CELL_COUNT);
        end
        return s[AW-1:0];
    endfunction

    // request fields
    assign w_acc  = i_s_tvalid && o_s_tready;
    assign w_req  = i_s_tuser;
    assign w_char = i_s_tdata[CHAR_W-1:0];
    assign w_idx  = i_s_tdata[CHAR_W +: INDEX_W];

    assign w_raddr    = ring_addr(SUM_W'(w_idx), r_base);
    assign w_oob      = SUM_W'(w_idx) >= SUM_W'(CELL_COUNT);
    assign w_cur_addr = ring_addr(SUM_W'(r_pos), r_base);

    // cursor advance by one cell
    assign w_adv_wrap   = (r_col == COL_W'(COLUMNS - 1));
    assign w_adv_scroll = w_adv_wrap && (r_row == ROW_W'(ROWS - 1));
    assign w_adv_col    = w_adv_wrap ? '0 : r_col + 1'b1;
    assign w_adv_row    = w_adv_wrap ? r_row + 1'b1 : r_row;
    assign w_adv_ph     = (w_adv_wrap || (r_ph == PH_W'(TAB_STOP - 1))) ? '0 : r_ph + 1'b1;

    // top-row offset after a scroll
    assign w_base_sum  = {1'b0, r_base} + (AW + 1)'(COLUMNS);
    assign w_base_next = (w_base_sum == (AW + 1)'(CELL_COUNT)) ? '0 : w_base_sum[AW-1:0];

    // cursor fields at output width
    assign w_col_ext = {{OUT_COL_W{1'b0}}, r_col};
    assign w_row_ext = {{OUT_ROW_W{1'b0}}, r_row};

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_cfg_ready = 1'b1;

    // sequencer: next state, cursor update and RAM write
    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_pos       = r_pos;
        n_ph        = r_ph;
        n_base      = r_base;
        n_clr_addr  = r_clr_addr;
        n_clr_cnt   = r_clr_cnt;
        n_res_data  = r_res_data;
        n_res_scr   = r_res_scr;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        w_we        = 1'b0;
        w_waddr     = w_cur_addr;
        w_wdata     = {r_attr, CHR_SPACE};

        case (r_state)
            S_INIT: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                w_wdata    = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(CELL_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_acc) begin
                    n_res_scr  = 1'b0;
                    n_res_data = '0;
                    n_state    = S_DONE;
                    if (w_req == REQ_READ) begin
                        n_state = S_READ;
                    end else if (w_char == CHR_LF) begin
                        n_col = '0;
                        n_ph  = '0;
                        if (r_row == ROW_W'(ROWS - 1)) begin
                            n_pos      = AW'(LAST_POS);
                            n_base     = w_base_next;
                            n_clr_addr = r_base;
                            n_clr_cnt  = '0;
                            n_res_scr  = 1'b1;
                            n_state    = S_SCROLL;
                        end else begin
                            n_row = r_row + 1'b1;
                            n_pos = r_pos - AW'(r_col) + AW'(COLUMNS);
                        end
                    end else if (w_char == CHR_CR) begin
                        n_col = '0;
                        n_ph  = '0;
                        n_pos = r_pos - AW'(r_col);
                    end else begin
                        // plain character or first blank of a tab
                        w_we       = 1'b1;
                        w_wdata    = {r_attr, (w_char == CHR_TAB) ? CHR_SPACE : w_char};
                        n_res_data = w_wdata;
                        n_col      = w_adv_col;
                        n_row      = w_adv_row;
                        n_pos      = r_pos + 1'b1;
                        n_ph       = w_adv_ph;
                        if (w_adv_scroll) begin
                            n_row      = ROW_W'(ROWS - 1);
                            n_pos      = AW'(LAST_POS);
                            n_base     = w_base_next;
                            n_clr_addr = r_base;
                            n_clr_cnt  = '0;
                            n_res_scr  = 1'b1;
                            n_state    = S_SCROLL;
                        end else if (w_char == CHR_TAB && w_adv_ph != '0) begin
                            n_state = S_TAB;
                        end
                    end
                end
            end
            S_READ: begin
                n_res_data = r_oob ? '0 : r_rd_data;
                n_state    = S_DONE;
            end
            S_TAB: begin
                w_we       = 1'b1;
                n_res_data = w_wdata;
                n_col      = w_adv_col;
                n_row      = w_adv_row;
                n_pos      = r_pos + 1'b1;
                n_ph       = w_adv_ph;
                if (w_adv_scroll) begin
                    n_row      = ROW_W'(ROWS - 1);
                    n_pos      = AW'(LAST_POS);
                    n_base     = w_base_next;
                    n_clr_addr = r_base;
                    n_clr_cnt  = '0;
                    n_res_scr  = 1'b1;
                    n_state    = S_SCROLL;
                end else if (w_adv_ph == '0) begin
                    n_state = S_DONE;
                end
            end
            S_SCROLL: begin
                // zero the recycled row, now the bottom one
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                w_wdata    = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                n_clr_cnt  = r_clr_cnt + 1'b1;
                if (r_clr_cnt == COL_W'(COLUMNS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {3'b000, r_res_scr, w_row_ext[OUT_ROW_W-1:0],
                                   w_col_ext[OUT_COL_W-1:0], r_res_data};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_col       <= '0;
            r_row       <= '0;
            r_pos       <= '0;
            r_ph        <= '0;
            r_base      <= '0;
            r_clr_addr  <= '0;
            r_clr_cnt   <= '0;
            r_attr      <= ATTR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_pos       <= n_pos;
            r_ph        <= n_ph;
            r_base      <= n_base;
            r_clr_addr  <= n_clr_addr;
            r_clr_cnt   <= n_clr_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_attr <= i_cfg_data;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_res_data <= n_res_data;
        r_res_scr  <= n_res_scr;
        r_out_data <= n_out_data;
        if (w_acc) begin
            r_oob <= w_oob;
        end
    end

    // screen RAM, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= mem[w_raddr];
    end

endmodule

@@ src/tccw_checker.sv @@
// port-level checks for the text console cell writer and their binding
module tccw_checker
    import tccw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int COL_LSB = CELL_W;
    localparam int ROW_LSB = CELL_W + OUT_COL_W;
    localparam int SCR_BIT = CELL_W + OUT_COL_W + OUT_ROW_W;

    // a stalled result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result word changed while stalled");

    // one request in work: no accept right after an accept
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken while previous one in work");

    // a scroll leaves the cursor at the start of the bottom row
    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[SCR_BIT]) |->
            (o_m_tdata[ROW_LSB +: OUT_ROW_W] == OUT_ROW_W'(ROWS - 1)
             && o_m_tdata[COL_LSB +: OUT_COL_W] == '0))
        else $error("scroll result with cursor off the bottom row start");

    // reported cursor stays on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (int'(o_m_tdata[ROW_LSB +: OUT_ROW_W]) < ROWS
                        && int'(o_m_tdata[COL_LSB +: OUT_COL_W]) < COLUMNS))
        else $error("cursor outside the screen");

endmodule

bind text_console_cell_writer tccw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tccw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
